@@ hw/rtl/bba_pkg.sv @@
package bba_pkg;

   // Table geometry
   localparam int TILE_SIZE = 65536;
   localparam int IDX_W     = $clog2(TILE_SIZE);
   localparam int ID_W      = 40;
   localparam int COORD_W   = 32;
   localparam int OP_W      = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_EXPAND     = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Empty-entry sentinels
   localparam logic signed [COORD_W-1:0] EMPTY_MIN_X = 32'sd2000000000;
   localparam logic signed [COORD_W-1:0] EMPTY_MIN_Y = 32'sd1000000000;
   localparam logic signed [COORD_W-1:0] EMPTY_MAX_X = -32'sd2000000000;
   localparam logic signed [COORD_W-1:0] EMPTY_MAX_Y = -32'sd1000000000;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   localparam box_type EMPTY_BOX = '{
      min_x: EMPTY_MIN_X,
      min_y: EMPTY_MIN_Y,
      max_x: EMPTY_MAX_X,
      max_y: EMPTY_MAX_Y
   };

   // Item as it enters the read-modify-write stage
   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic                      in_range;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } item_type;

   // Table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      box_type          data;
   } wr_type;

   // Result word
   typedef struct packed {
      logic    status;
      logic    box_valid;
      box_type box;
   } result_type;

endpackage

@@ hw/rtl/bba_ram.sv @@
module bba_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bba_rmw.sv @@
module bba_rmw (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  bba_pkg::item_type     item,
   input  bba_pkg::box_type      rd_data,
   output bba_pkg::wr_type       wr,
   output logic                  res_valid,
   output bba_pkg::result_type   res
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   bba_pkg::item_type             s1_item_ff;
   logic                          fwd_valid_ff;
   logic [bba_pkg::IDX_W-1:0]     fwd_idx_ff;
   bba_pkg::box_type              fwd_box_ff;
   bba_pkg::box_type              cur_box;
   bba_pkg::box_type              new_box;
   bba_pkg::box_type              out_box;

   assign s1_valid_in = take;

   // Hold the item while its entry is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_item_ff <= item;
      end
   end

   // Keep the last write; a read at the same edge as that write returns old data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr.en;
      end
   end

   always_ff @(posedge clock) begin
      fwd_idx_ff <= wr.idx;
      fwd_box_ff <= wr.data;
   end

   // Select forwarded entry on a hit
   always_comb begin
      if (fwd_valid_ff && (fwd_idx_ff == s1_item_ff.idx)) begin
         cur_box = fwd_box_ff;
      end else begin
         cur_box = rd_data;
      end
   end

   // Widen the box to take in the point
   always_comb begin
      new_box.min_x = (s1_item_ff.x < cur_box.min_x) ? s1_item_ff.x : cur_box.min_x;
      new_box.min_y = (s1_item_ff.y < cur_box.min_y) ? s1_item_ff.y : cur_box.min_y;
      new_box.max_x = (s1_item_ff.x > cur_box.max_x) ? s1_item_ff.x : cur_box.max_x;
      new_box.max_y = (s1_item_ff.y > cur_box.max_y) ? s1_item_ff.y : cur_box.max_y;
   end

   // Decide write-back and result box per operation
   always_comb begin
      wr.idx  = s1_item_ff.idx;
      wr.data = bba_pkg::EMPTY_BOX;
      wr.en   = 1'b0;
      out_box = cur_box;
      case (s1_item_ff.op)
         bba_pkg::OP_EXPAND: begin
            wr.en   = s1_valid_ff && s1_item_ff.in_range;
            wr.data = new_box;
            out_box = new_box;
         end
         bba_pkg::OP_READ_CLEAR: begin
            wr.en   = s1_valid_ff && s1_item_ff.in_range;
            wr.data = bba_pkg::EMPTY_BOX;
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
   end

   // Build the result word
   always_comb begin
      if (s1_item_ff.in_range) begin
         res.status    = bba_pkg::STATUS_OK;
         res.box       = out_box;
         res.box_valid = out_box.min_x < bba_pkg::EMPTY_MIN_X;
      end else begin
         res.status    = bba_pkg::STATUS_RANGE;
         res.box       = '0;
         res.box_valid = 1'b0;
      end
   end

   assign res_valid = s1_valid_ff;

endmodule

@@ hw/rtl/bba_rsp_queue.sv @@
module bba_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bba_pkg::result_type  push_data,
   input  logic                 pop,
   output logic                 not_empty,
   output logic [1:0]           count,
   output bba_pkg::result_type  head
);

   bba_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = count_ff != 2'd0;
   assign count     = count_ff;

endmodule

@@ hw/rtl/bounding_box_accumulator_table.sv @@
// Bounding-box table: one box (min x, min y, max x, max y) per item id in a
// tile of TILE_SIZE ids starting at tile_base.
// Channels: req_* carries one word per item (op, item_id, point_x, point_y);
// rsp_* returns exactly one word per item, in order (status, box_valid, box).
// csr_* writes tile_base; csr_ready is always high. Write it only while idle.
// An accepted item is registered in the read-modify-write stage and its result
// in the result queue, which drives rsp_*. Throughput: one item per cycle while
// req_ready is high. The read-modify-write of an entry spans the memory read
// cycle and the write-back cycle; a write is forwarded to an item that reads
// the same entry in the following cycle. Reset: tile_base returns to 0 and a
// clearing pass writes the empty box into every entry, one entry a cycle;
// req_ready is low throughout, csr writes are taken.
// Stall: two result words can wait on rsp_*; req_ready drops when the
// waiting words and the item in flight would leave no room for another item.
module bounding_box_accumulator_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bba_pkg::ID_W-1:0]            csr_tile_base,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bba_pkg::OP_W-1:0]            req_op,
   input  logic [bba_pkg::ID_W-1:0]            req_item_id,
   input  logic signed [bba_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [bba_pkg::COORD_W-1:0]  req_point_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_status,
   output logic                                rsp_box_valid,
   output logic signed [bba_pkg::COORD_W-1:0]  rsp_box_min_x,
   output logic signed [bba_pkg::COORD_W-1:0]  rsp_box_min_y,
   output logic signed [bba_pkg::COORD_W-1:0]  rsp_box_max_x,
   output logic signed [bba_pkg::COORD_W-1:0]  rsp_box_max_y
);

   localparam logic [bba_pkg::IDX_W-1:0] LAST_IDX = bba_pkg::IDX_W'(bba_pkg::TILE_SIZE - 1);
   localparam logic [bba_pkg::ID_W-1:0]  TILE_SPAN = bba_pkg::ID_W'(bba_pkg::TILE_SIZE);

   logic [bba_pkg::ID_W-1:0]   tile_base_ff;
   logic [bba_pkg::ID_W-1:0]   tile_base_in;
   logic                       clr_busy_ff;
   logic                       clr_busy_in;
   logic [bba_pkg::IDX_W-1:0]  clr_idx_ff;
   logic [bba_pkg::IDX_W-1:0]  clr_idx_in;
   logic [bba_pkg::ID_W:0]     offset;
   bba_pkg::item_type          item;
   logic                       take;
   logic                       pop;
   logic [2:0]                 occupancy;
   bba_pkg::wr_type            rmw_wr;
   bba_pkg::box_type           rd_box;
   logic [bba_pkg::BOX_W-1:0]  rd_raw;
   logic                       res_valid;
   bba_pkg::result_type        res;
   logic                       q_not_empty;
   logic [1:0]                 q_count;
   bba_pkg::result_type        head;
   logic                       ram_wr_en;
   logic [bba_pkg::IDX_W-1:0]  ram_wr_addr;
   logic [bba_pkg::BOX_W-1:0]  ram_wr_data;

   // Configuration register
   assign csr_ready    = 1'b1;
   assign tile_base_in = csr_valid ? csr_tile_base : tile_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_base_ff <= '0;
      end else begin
         tile_base_ff <= tile_base_in;
      end
   end

   // Clearing pass after reset
   always_comb begin
      clr_busy_in = clr_busy_ff && (clr_idx_ff != LAST_IDX);
      clr_idx_in  = clr_busy_ff ? clr_idx_ff + 1'b1 : clr_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Tile range check and entry index
   always_comb begin
      offset        = {1'b0, req_item_id} - {1'b0, tile_base_ff};
      item.op       = req_op;
      item.in_range = !offset[bba_pkg::ID_W] && (offset[bba_pkg::ID_W-1:0] < TILE_SPAN);
      item.idx      = offset[bba_pkg::IDX_W-1:0];
      item.x        = req_point_x;
      item.y        = req_point_y;
   end

   // Accept while the result queue has room for this item and the one in flight
   assign pop       = q_not_empty && rsp_ready;
   assign occupancy = {1'b0, q_count} + {2'b00, res_valid} - {2'b00, pop};
   assign req_ready = !clr_busy_ff && (occupancy < 3'd2);
   assign take      = req_valid && req_ready;

   // Table write port: clearing pass or write-back
   always_comb begin
      if (clr_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = bba_pkg::EMPTY_BOX;
      end else begin
         ram_wr_en   = rmw_wr.en;
         ram_wr_addr = rmw_wr.idx;
         ram_wr_data = rmw_wr.data;
      end
   end

   bba_ram #(
      .WIDTH (bba_pkg::BOX_W),
      .DEPTH (bba_pkg::TILE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (item.idx),
      .rd_data (rd_raw)
   );

   assign rd_box = rd_raw;

   bba_rmw u_rmw (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .item      (item),
      .rd_data   (rd_box),
      .wr        (rmw_wr),
      .res_valid (res_valid),
      .res       (res)
   );

   bba_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (pop),
      .not_empty (q_not_empty),
      .count     (q_count),
      .head      (head)
   );

   // Drive the result word
   assign rsp_valid     = q_not_empty;
   assign rsp_status    = head.status;
   assign rsp_box_valid = head.box_valid;
   assign rsp_box_min_x = head.box.min_x;
   assign rsp_box_min_y = head.box.min_y;
   assign rsp_box_max_x = head.box.max_x;
   assign rsp_box_max_y = head.box.max_y;

endmodule
